@@ rtl/bfgt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgt_pkg
// Shared constants, codes and transaction types of the best-fit gap table.
// ----------------------------------------------------------------------------
package bfgt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ROWS_MAX    = 256;

   localparam int LEN_W   = 10;
   localparam int ROW_W   = 8;
   localparam int PLACE_W = 10;
   localparam int FLOOR_W = 8;
   localparam int KEY_W   = LEN_W + ROW_W + PLACE_W;
   localparam int ENTRY_W = KEY_W + FLOOR_W;

   localparam int OP_W      = 3;
   localparam int NROWS_W   = 9;
   localparam int COUNT_W   = 9;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 10;
   localparam int REQ_DAT_W = 40;
   localparam int RSP_DAT_W = 40;

   // operation codes
   localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 1'b1;

   typedef struct packed {
      logic [FLOOR_W-1:0] floor_lvl;
      logic [PLACE_W-1:0] place;
      logic [ROW_W-1:0]   row;
      logic [LEN_W-1:0]   gap_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic [FLOOR_W-1:0]  fit_floor;
      logic [PLACE_W-1:0]  fit_place;
      logic [ROW_W-1:0]    fit_row;
      logic                found;
   } rsp_type;

endpackage

@@ rtl/bfgt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bfgt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgt_ctrl
// Operation sequencer: table scans, init fill, valid bits, entry count.
// ----------------------------------------------------------------------------
module bfgt_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bfgt_pkg::OP_W-1:0]       req_op,
   input  bfgt_pkg::req_type               req_fields,
   // configuration
   input  logic                            csr_valid,
   input  logic [bfgt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfgt_pkg::CSR_DAT_W-1:0]  csr_data,
   // result
   output logic                            res_valid,
   input  logic                            res_ready,
   output bfgt_pkg::rsp_type               res,
   // table memory
   output logic                            mem_wr_en,
   output logic [bfgt_pkg::IDX_W-1:0]      mem_wr_addr,
   output logic [bfgt_pkg::ENTRY_W-1:0]    mem_wr_data,
   output logic                            mem_rd_en,
   output logic [bfgt_pkg::IDX_W-1:0]      mem_rd_addr,
   input  logic [bfgt_pkg::ENTRY_W-1:0]    mem_rd_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FILL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam int D  = bfgt_pkg::TABLE_DEPTH;
   localparam int IW = bfgt_pkg::IDX_W;
   localparam int CW = bfgt_pkg::CNT_W;
   localparam int KW = bfgt_pkg::KEY_W;
   localparam int FW = bfgt_pkg::FLOOR_W;
   localparam int LW = bfgt_pkg::LEN_W;

   logic [1:0]                         state_ff, state_in;
   logic [D-1:0]                       valid_ff, valid_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic                               chk_ff, chk_in;
   logic [IW-1:0]                      chk_idx_ff, chk_idx_in;
   logic [bfgt_pkg::NROWS_W-1:0]       num_rows_ff, num_rows_in;
   logic [LW-1:0]                      row_len_ff, row_len_in;

   logic [bfgt_pkg::OP_W-1:0]          op_ff, op_in;
   bfgt_pkg::req_type                  fld_ff, fld_in;
   logic                               hit_ff, hit_in;
   logic [IW-1:0]                      hit_idx_ff, hit_idx_in;
   logic                               dup_ff, dup_in;
   logic                               free_ok_ff, free_ok_in;
   logic [IW-1:0]                      free_idx_ff, free_idx_in;
   logic [KW-1:0]                      best_key_ff, best_key_in;
   logic [FW-1:0]                      best_floor_ff, best_floor_in;
   logic                               full_ff, full_in;
   logic [CW-1:0]                      lim_ff, lim_in;
   bfgt_pkg::rsp_type                  res_ff, res_in;

   logic [bfgt_pkg::NROWS_W-1:0]       rows_capped;
   logic                               rows_over;
   logic [KW-1:0]                      ent_key;
   logic [KW-1:0]                      qry_key;
   logic                               ent_valid;
   logic                               scan_end;

   assign ent_key   = mem_rd_data[bfgt_pkg::ENTRY_W-1:FW];
   assign qry_key   = {fld_ff.gap_length, fld_ff.row, fld_ff.place};
   assign ent_valid = valid_ff[chk_idx_ff];
   assign scan_end  = (state_ff == S_SCAN) && (cnt_ff == CW'(D)) && !chk_ff;

   // rows that init loads: clip to the row range, then to the table depth
   assign rows_capped = (num_rows_ff > bfgt_pkg::NROWS_W'(bfgt_pkg::ROWS_MAX)) ?
                        bfgt_pkg::NROWS_W'(bfgt_pkg::ROWS_MAX) : num_rows_ff;
   assign rows_over   = 32'(rows_capped) > D;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      cnt_in        = cnt_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      num_rows_in   = num_rows_ff;
      row_len_in    = row_len_ff;
      op_in         = op_ff;
      fld_in        = fld_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      dup_in        = dup_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      best_key_in   = best_key_ff;
      best_floor_in = best_floor_ff;
      full_in       = full_ff;
      lim_in        = lim_ff;
      res_in        = res_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = cnt_ff[IW-1:0];

      if (csr_valid) begin
         case (csr_index)
            bfgt_pkg::CSR_NUM_ROWS:   num_rows_in = csr_data[bfgt_pkg::NROWS_W-1:0];
            bfgt_pkg::CSR_ROW_LENGTH: row_len_in  = csr_data[LW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               fld_in     = req_fields;
               cnt_in     = '0;
               hit_in     = 1'b0;
               dup_in     = 1'b0;
               free_ok_in = 1'b0;
               res_in     = '0;
               case (req_op)
                  bfgt_pkg::OP_INIT: begin
                     valid_in = '0;
                     count_in = '0;
                     full_in  = rows_over;
                     lim_in   = rows_over ? CW'(D) : CW'(rows_capped);
                     if (rows_capped == '0) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_FILL;
                     end
                  end
                  bfgt_pkg::OP_CLEAR: begin
                     valid_in = '0;
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  bfgt_pkg::OP_INSERT, bfgt_pkg::OP_REMOVE, bfgt_pkg::OP_QUERY: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in.entry_count = bfgt_pkg::COUNT_W'(count_ff);
                     state_in           = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue one read a cycle, check the entry read the cycle before
            if (cnt_ff != CW'(D)) begin
               mem_rd_en  = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = cnt_ff[IW-1:0];
            end
            if (chk_ff) begin
               case (op_ff)
                  bfgt_pkg::OP_INSERT: begin
                     if (ent_valid && ent_key == qry_key) begin
                        dup_in = 1'b1;
                     end
                     if (!ent_valid && !free_ok_ff) begin
                        free_ok_in  = 1'b1;
                        free_idx_in = chk_idx_ff;
                     end
                  end
                  bfgt_pkg::OP_REMOVE: begin
                     if (ent_valid && ent_key == qry_key && !hit_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = chk_idx_ff;
                     end
                  end
                  bfgt_pkg::OP_QUERY: begin
                     if (ent_valid && ent_key[KW-1:KW-LW] >= fld_ff.gap_length &&
                         (!hit_ff || ent_key < best_key_ff)) begin
                        hit_in        = 1'b1;
                        best_key_in   = ent_key;
                        best_floor_in = mem_rd_data[FW-1:0];
                     end
                  end
                  default: ;
               endcase
            end
            if (scan_end) begin
               res_in = '0;
               case (op_ff)
                  bfgt_pkg::OP_INSERT: begin
                     if (dup_ff) begin
                        res_in.status = bfgt_pkg::ST_DUP;
                     end else if (!free_ok_ff) begin
                        res_in.status = bfgt_pkg::ST_FULL;
                     end else begin
                        mem_wr_en             = 1'b1;
                        mem_wr_addr           = free_idx_ff;
                        mem_wr_data           = {qry_key, fld_ff.floor_lvl};
                        valid_in[free_idx_ff] = 1'b1;
                        count_in              = count_ff + 1'b1;
                     end
                  end
                  bfgt_pkg::OP_REMOVE: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        count_in             = count_ff - 1'b1;
                     end else begin
                        res_in.status = bfgt_pkg::ST_NONE;
                     end
                  end
                  default: begin
                     if (hit_ff) begin
                        res_in.found     = 1'b1;
                        res_in.fit_row   = best_key_ff[bfgt_pkg::ROW_W+bfgt_pkg::PLACE_W-1:
                                                       bfgt_pkg::PLACE_W];
                        res_in.fit_place = best_key_ff[bfgt_pkg::PLACE_W-1:0];
                        res_in.fit_floor = best_floor_ff;
                     end else begin
                        res_in.status = bfgt_pkg::ST_NONE;
                     end
                  end
               endcase
               res_in.entry_count = bfgt_pkg::COUNT_W'(count_in);
               state_in           = S_DONE;
            end
         end

         S_FILL: begin
            // write one init row a cycle
            mem_wr_en                = 1'b1;
            mem_wr_addr              = cnt_ff[IW-1:0];
            mem_wr_data              = {row_len_ff, bfgt_pkg::ROW_W'(cnt_ff),
                                        bfgt_pkg::PLACE_W'(0), FW'(0)};
            valid_in[cnt_ff[IW-1:0]] = 1'b1;
            cnt_in                   = cnt_ff + 1'b1;
            if (CW'(cnt_ff + 1'b1) == lim_ff) begin
               count_in           = lim_ff;
               res_in.status      = full_ff ? bfgt_pkg::ST_FULL : bfgt_pkg::ST_OK;
               res_in.entry_count = bfgt_pkg::COUNT_W'(lim_ff);
               state_in           = S_DONE;
            end
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         count_ff    <= '0;
         chk_ff      <= 1'b0;
         num_rows_ff <= bfgt_pkg::NROWS_W'(1);
         row_len_ff  <= LW'(1);
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         chk_ff      <= chk_in;
         num_rows_ff <= num_rows_in;
         row_len_ff  <= row_len_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      op_ff         <= op_in;
      fld_ff        <= fld_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      dup_ff        <= dup_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      best_key_ff   <= best_key_in;
      best_floor_ff <= best_floor_in;
      full_ff       <= full_in;
      lim_ff        <= lim_in;
      res_ff        <= res_in;
   end

endmodule

@@ rtl/bfgt_rsp_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgt_rsp_reg
// Result output register; frees the sequencer while a result waits.
// ----------------------------------------------------------------------------
module bfgt_rsp_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            res_valid,
   output logic                            res_ready,
   input  bfgt_pkg::rsp_type               res,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfgt_pkg::RSP_DAT_W-1:0]  rsp_tdata
);

   logic                           vld_ff, vld_in;
   logic [bfgt_pkg::RSP_DAT_W-1:0] dat_ff, dat_in;

   assign res_ready = !vld_ff || rsp_tready;

   always_comb begin
      vld_in = vld_ff;
      dat_in = dat_ff;
      if (res_ready) begin
         vld_in = res_valid;
         if (res_valid) begin
            dat_in = bfgt_pkg::RSP_DAT_W'(res);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dat_ff <= dat_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = dat_ff;

endmodule

@@ rtl/best_fit_gap_table_core.sv @@
`timescale 1ns / 1ps
// Operations: insert, remove and best-fit scan the whole table before the result goes to
//   rsp_tvalid; init writes each loaded row, clear and spare ops skip the scan.
// Flow: one operation at a time; the next request is taken in the cycle after the
//   result moves into the output register.
// Reset: synchronous, active high; clears every valid bit at once, zeroes the entry count
//   and sets num_rows and row_length to 1. No clearing pass.
// ----------------------------------------------------------------------------
// best_fit_gap_table_core
// Table of free gaps keyed by (length, row, place) with best-fit lookup.
// ----------------------------------------------------------------------------
module best_fit_gap_table_core (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] gap_length, [17:10] row, [27:18] place, [35:28] floor, [39:36] zero
   input  logic [bfgt_pkg::REQ_DAT_W-1:0]  req_tdata,
   // [2:0] op
   input  logic [bfgt_pkg::OP_W-1:0]       req_tuser,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] found, [8:1] fit_row, [18:9] fit_place, [26:19] fit_floor,
   // [35:27] entry_count, [37:36] status, [39:38] zero
   output logic [bfgt_pkg::RSP_DAT_W-1:0]  rsp_tdata,
   // configuration write channel: index 0 num_rows, 1 row_length
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bfgt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfgt_pkg::CSR_DAT_W-1:0]  csr_data
);

   bfgt_pkg::req_type               req_fields;
   bfgt_pkg::rsp_type               res;
   logic                            res_valid;
   logic                            res_ready;
   logic                            mem_wr_en;
   logic [bfgt_pkg::IDX_W-1:0]      mem_wr_addr;
   logic [bfgt_pkg::ENTRY_W-1:0]    mem_wr_data;
   logic                            mem_rd_en;
   logic [bfgt_pkg::IDX_W-1:0]      mem_rd_addr;
   logic [bfgt_pkg::ENTRY_W-1:0]    mem_rd_data;

   // writes apply in any cycle; software must write while the block is idle; unenforced
   assign csr_ready = 1'b1;

   // unpack the request payload; the pad bits above the fields are dropped
   assign req_fields = req_tdata[$bits(bfgt_pkg::req_type)-1:0];

   // sequencer: scans, init fill, valid bits and entry count
   bfgt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_fields  (req_fields),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // gap entries: {length, row, place, floor}; validity lives in the sequencer
   bfgt_ram #(
      .WIDTH (bfgt_pkg::ENTRY_W),
      .DEPTH (bfgt_pkg::TABLE_DEPTH)
   ) u_gap_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // hold the finished result so the next request can start
   bfgt_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/bfgt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgt_checker
// Port-level checks of the best-fit gap table result stream.
// ----------------------------------------------------------------------------
module bfgt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bfgt_pkg::RSP_DAT_W-1:0]  rsp_tdata
);

   // no result right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // entry count never exceeds the table depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[35:27]) <= bfgt_pkg::TABLE_DEPTH)
      else $error("entry count above table depth");

   // a hit always reports ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[37:36] == bfgt_pkg::ST_OK)
      else $error("hit with non-ok status");

   // without a hit the fit fields are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[26:1] == '0)
      else $error("fit fields set without a hit");

endmodule

bind best_fit_gap_table_core bfgt_checker u_bfgt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
